// ===== sv/css_comment_stripper_core_macros.svh =====
// assertion macros shared by the checker of the comment stripper core
`ifndef CSS_COMMENT_STRIPPER_CORE_MACROS_SVH
`define CSS_COMMENT_STRIPPER_CORE_MACROS_SVH

// same-cycle implication, sampled on the rising clock, off while in reset
`define CSS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on the rising clock, off while in reset
`define CSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/css_pkg.sv =====
// package: scan modes, character codes and the decoded result bundle
package css_pkg;

	// characters that steer the scanner
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_STAR   = 8'h2A;

	// entries in the output queue, indexed by two-bit pointers
	localparam int unsigned OBUF_DEPTH = 4;

	// scanner mode
	typedef enum logic [2:0] {
		MODE_PLAIN   = 3'd0,
		MODE_SQUOTE  = 3'd1,
		MODE_DQUOTE  = 3'd2,
		MODE_SLASH   = 3'd3,
		MODE_COMMENT = 3'd4,
		MODE_STAR    = 3'd5
	} scan_mode_t;

	// bytes produced by one input item (cnt is 0, 1 or 2)
	typedef struct packed {
		logic [1:0] cnt;
		logic [7:0] b0;
		logic [7:0] b1;
	} scan_res_t;

endpackage

// ===== sv/css_scan.sv =====
// input register, mode register and per-item decode of the comment scanner
module css_scan
	import css_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	output logic       res_valid,
	output scan_res_t  res,
	input  logic       res_take
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	scan_mode_t mode_q;
	scan_mode_t mode_nxt;
	logic       load;

	// input stage refills when empty or when its item moves on
	assign load      = !valid_s1 || res_take;
	assign in_stall  = !load;
	assign res_valid = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && in_valid) begin
			byte_s1 <= in_byte;
		end
	end

	// mode advances only when the decoded item is handed on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_PLAIN;
		end else if (valid_s1 && res_take) begin
			mode_q <= mode_nxt;
		end
	end

	// decode of one byte against the current mode
	always_comb begin
		mode_nxt = mode_q;
		res.cnt  = 2'd0;
		res.b0   = byte_s1;
		res.b1   = byte_s1;
		unique case (mode_q)
			MODE_SQUOTE: begin
				if (byte_s1 == CH_SQUOTE) begin
					mode_nxt = MODE_PLAIN;
				end
				res.cnt = 2'd1;
			end
			MODE_DQUOTE: begin
				if (byte_s1 == CH_DQUOTE) begin
					mode_nxt = MODE_PLAIN;
				end
				res.cnt = 2'd1;
			end
			MODE_SLASH: begin
				if (byte_s1 == CH_SLASH) begin
					res.cnt = 2'd1;
					res.b0  = CH_SLASH;
				end else if (byte_s1 == CH_STAR) begin
					mode_nxt = MODE_COMMENT;
				end else begin
					// held slash goes out ahead of this byte
					mode_nxt = MODE_PLAIN;
					res.cnt  = 2'd2;
					res.b0   = CH_SLASH;
					res.b1   = byte_s1;
				end
			end
			MODE_COMMENT: begin
				if (byte_s1 == CH_STAR) begin
					mode_nxt = MODE_STAR;
				end
			end
			MODE_STAR: begin
				if (byte_s1 == CH_SLASH) begin
					mode_nxt = MODE_PLAIN;
				end else if (byte_s1 != CH_STAR) begin
					mode_nxt = MODE_COMMENT;
				end
			end
			default: begin
				// plain text, also any unused code
				mode_nxt = MODE_PLAIN;
				if (byte_s1 == CH_SQUOTE) begin
					mode_nxt = MODE_SQUOTE;
					res.cnt  = 2'd1;
				end else if (byte_s1 == CH_DQUOTE) begin
					mode_nxt = MODE_DQUOTE;
					res.cnt  = 2'd1;
				end else if (byte_s1 == CH_SLASH) begin
					mode_nxt = MODE_SLASH;
				end else begin
					res.cnt = 2'd1;
				end
			end
		endcase
	end

endmodule

// ===== sv/css_obuf.sv =====
// four-entry output queue that takes up to two bytes per item
module css_obuf
	import css_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       res_valid,
	input  scan_res_t  res,
	output logic       res_take,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       last_of_run
);

	logic [7:0] byte_q [OBUF_DEPTH];
	logic       last_q [OBUF_DEPTH];
	logic [1:0] wr_q;
	logic [1:0] rd_q;
	logic [2:0] cnt_q;
	logic       push;
	logic       pop;
	logic [1:0] push_n;
	logic [1:0] wr_p1;

	// room for the largest item (two bytes)
	assign res_take  = cnt_q <= 3'd2;
	assign push      = res_valid && res_take;
	assign push_n    = push ? res.cnt : 2'd0;
	assign out_valid = cnt_q != 3'd0;
	assign pop       = out_valid && !out_stall;
	assign wr_p1     = wr_q + 2'd1;

	assign out_byte    = byte_q[rd_q];
	assign last_of_run = last_q[rd_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 2'd0;
			rd_q  <= 2'd0;
			cnt_q <= 3'd0;
		end else begin
			wr_q  <= wr_q + push_n;
			rd_q  <= rd_q + {1'b0, pop};
			cnt_q <= cnt_q + {1'b0, push_n} - {2'b00, pop};
		end
	end

	// entry writes, second byte one slot after the first
	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			byte_q[wr_q] <= res.b0;
			last_q[wr_q] <= push_n == 2'd1;
		end
		if (push_n == 2'd2) begin
			byte_q[wr_p1] <= res.b1;
			last_q[wr_p1] <= 1'b1;
		end
	end

endmodule

// ===== sv/css_comment_stripper_core.sv =====
// top level of the block comment stripper
//
//  channel | signals                              | direction
//  --------+--------------------------------------+----------
//  input   | in_valid, in_stall, in_byte          | byte in
//  output  | out_valid, out_stall, out_byte,      | byte out
//          | last_of_run                          |
//
// one input byte per cycle unless the input stalls: the byte is registered,
// decoded combinationally against the mode register and written as zero, one
// or two bytes into a four-entry output queue; one queued byte leaves per
// cycle unless the output stalls.
// reset clears the mode to plain text and empties both stages.
// input stalls only when the queue has fewer than two free entries.
module css_comment_stripper_core
	import css_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       last_of_run
);

	logic      res_valid;
	logic      res_take;
	scan_res_t res;

	// scanner
	css_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_byte   (in_byte),
		.res_valid (res_valid),
		.res       (res),
		.res_take  (res_take)
	);

	// output queue
	css_obuf u_obuf (
		.clk         (clk),
		.arst_n      (arst_n),
		.res_valid   (res_valid),
		.res         (res),
		.res_take    (res_take),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.last_of_run (last_of_run)
	);

endmodule

// ===== sv/css_checker.sv =====
// port checker of the comment stripper core and its bind
`include "css_comment_stripper_core_macros.svh"

module css_checker
	import css_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [7:0] in_byte,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_byte,
	input logic       last_of_run
);

	// a stalled input item stays offered and unchanged
	`CSS_ASSERT_NEXT(a_in_hold, clk, arst_n, in_valid && in_stall,
		in_valid && $stable(in_byte), "in item changed while stalled")

	// a stalled output item stays offered
	`CSS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid,
		"out item dropped")

	// a stalled output byte does not change
	`CSS_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && out_stall,
		$stable(out_byte) && $stable(last_of_run), "out item changed")

	// only a held slash is ever the first of two bytes
	`CSS_ASSERT_SAME(a_first_is_slash, clk, arst_n, out_valid && !last_of_run,
		out_byte == CH_SLASH, "first of two is not slash")

	// nothing is offered right after reset
	`CSS_ASSERT_SAME(a_empty_after_reset, clk, arst_n, $rose(arst_n), !out_valid,
		"output valid after reset")

endmodule

bind css_comment_stripper_core css_checker u_css_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.in_byte     (in_byte),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.out_byte    (out_byte),
	.last_of_run (last_of_run)
);
